### rtl/fcs_pkg.sv
package fcs_pkg;

    localparam int unsigned LANES_MAX = 4;
    localparam int unsigned MOTORS_DEF = 4;
    localparam int unsigned POS_W = 20;
    localparam int unsigned FRC_W = 24;

    localparam logic [31:0] RUN_LIMIT_MS = 32'd120000;
    localparam logic [31:0] STEP_GAP_MS = 32'd500;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STG_IDLE     = 3'd0,
        STG_COARSE   = 3'd1,
        STG_FINE     = 3'd2,
        STG_HOLD     = 3'd3,
        STG_COMPLETE = 3'd4,
        STG_ERROR    = 3'd5
    } t_stage;

    localparam logic [1:0] FLT_NONE = 2'd0;
    localparam logic [1:0] FLT_TIMEOUT = 2'd1;
    localparam logic [1:0] FLT_MOTOR = 2'd2;

    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_RATE = 3'd1;
    localparam logic [2:0] REG_GOAL_A = 3'd2;
    localparam logic [2:0] REG_GOAL_B = 3'd3;
    localparam logic [2:0] REG_GOAL_C = 3'd4;
    localparam logic [2:0] REG_GOAL_D = 3'd5;
    localparam logic [2:0] REG_COUNT = 3'd6;
    localparam logic [2:0] REG_BAND = 3'd7;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_EVAL = 2'd1,
        SEQ_OUT  = 2'd2
    } t_seq;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_ms;
        logic signed [19:0] pos_a;
        logic signed [19:0] pos_b;
        logic signed [19:0] pos_c;
        logic signed [19:0] pos_d;
        logic signed [23:0] force_a;
        logic signed [23:0] force_b;
        logic signed [23:0] force_c;
        logic signed [23:0] force_d;
    } t_in_word;

    typedef struct packed {
        logic        busy_res;
        logic [2:0]  stage;
        logic [6:0]  percent;
        logic [1:0]  fault;
        logic [31:0] elapsed;
        logic [3:0]  move_mask;
        logic signed [19:0] goal_a;
        logic signed [19:0] goal_b;
        logic signed [19:0] goal_c;
        logic signed [19:0] goal_d;
        logic [3:0]  active_bits;
    } t_out_word;

    // Per-lane decisions handed to the merge stage.
    typedef struct packed {
        logic coarse_done;
        logic fine_done;
        logic hold_in;
        logic hold_low;
        logic signed [19:0] coarse_goal;
        logic signed [19:0] fine_goal;
        logic signed [19:0] hold_goal;
    } t_lane_res;

    // Saturating clamp of a 22-bit difference onto the position range.
    function automatic logic signed [19:0] sat_pos(input logic signed [21:0] v);
        logic signed [21:0] lo;
        logic signed [21:0] hi;
        begin
            lo = -22'sd524288;
            hi = 22'sd524287;
            if (v < lo) begin
                sat_pos = -20'sd524288;
            end else if (v > hi) begin
                sat_pos = 20'sd524287;
            end else begin
                sat_pos = v[19:0];
            end
        end
    endfunction

    // Progress step: base + span*cnt/n for n in 1..4, cnt in 0..4.
    function automatic logic [6:0] prog(input logic [6:0] base, input logic [6:0] span,
                                        input logic [2:0] cnt, input logic [2:0] n);
        logic [9:0] num;
        logic [6:0] q;
        begin
            num = 10'(span) * 10'(cnt);
            case (n)
                3'd1: q = num[6:0];
                3'd2: q = num[7:1];
                3'd3: q = 7'((20'(num) * 20'd683) >> 11);
                3'd4: q = num[8:2];
                default: q = 7'd0;
            endcase
            prog = base + q;
        end
    endfunction

endpackage

### rtl/fcs_lane.sv
module fcs_lane (
    input  logic signed [19:0] i_pos,
    input  logic signed [23:0] i_frc,
    input  logic signed [23:0] i_goal,
    input  logic signed [19:0] i_target,
    input  logic [15:0]        i_band,
    input  logic [9:0]         i_step,
    output fcs_pkg::t_lane_res o_res
);
    import fcs_pkg::*;

    logic signed [25:0] lo;
    logic signed [25:0] hi;
    logic signed [21:0] c_nx;

    always_comb begin
        lo = 26'(i_goal) - 26'(signed'({1'b0, i_band}));
        hi = 26'(i_goal) + 26'(signed'({1'b0, i_band}));
        c_nx = 22'(i_pos) - 22'sd1000;
        o_res.coarse_done = (i_pos <= i_target);
        o_res.coarse_goal = (c_nx < 22'(i_target)) ? i_target : c_nx[19:0];
        o_res.fine_done = (26'(i_frc) >= lo);
        o_res.fine_goal = sat_pos(22'(i_pos) - 22'(signed'({1'b0, i_step})));
        o_res.hold_low = (26'(i_frc) < lo);
        o_res.hold_in = (26'(i_frc) >= lo) && (26'(i_frc) <= hi);
        o_res.hold_goal = sat_pos(22'(i_pos) - 22'sd10);
    end
endmodule

### rtl/fcs_ctrl.sv
module fcs_ctrl #(
    parameter int unsigned MOTORS = fcs_pkg::MOTORS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  fcs_pkg::t_in_word   i_word,
    input  fcs_pkg::t_lane_res  i_lane [4],
    input  logic [2:0]          i_count,
    output fcs_pkg::t_out_word  o_word
);
    import fcs_pkg::*;

    localparam int unsigned LIM = (MOTORS < LANES_MAX) ? MOTORS : LANES_MAX;

    logic r_run;
    t_stage r_stage;
    logic [31:0] r_start, r_elapsed;
    logic [3:0] r_active, r_done;
    logic [31:0] r_last [3];
    logic [6:0] r_pct;
    logic [1:0] r_fault;
    logic signed [23:0] r_peak [4];

    logic n_run;
    t_stage n_stage;
    logic [31:0] n_start, n_elapsed;
    logic [3:0] n_active, n_done;
    logic [31:0] n_last [3];
    logic [6:0] n_pct;
    logic [1:0] n_fault;
    logic signed [23:0] n_peak [4];
    logic [3:0] mv;
    logic signed [19:0] g [4];
    logic [2:0] nl, cnt;
    logic all_d;
    logic signed [23:0] frc [4];

    always_comb begin
        frc[0] = i_word.force_a;
        frc[1] = i_word.force_b;
        frc[2] = i_word.force_c;
        frc[3] = i_word.force_d;
        nl = (i_count < 3'(LIM)) ? i_count : 3'(LIM);
        n_run = r_run; n_stage = r_stage; n_start = r_start; n_elapsed = r_elapsed;
        n_active = r_active; n_done = r_done; n_last = r_last; n_pct = r_pct;
        n_fault = r_fault; n_peak = r_peak;
        mv = '0; cnt = '0; all_d = 1'b1;
        for (int k = 0; k < 4; k++) g[k] = '0;
        case (t_cmd'(i_word.command))
            CMD_START: begin
                if (i_count == 3'd0) begin
                    n_fault = FLT_MOTOR; n_stage = STG_ERROR; n_run = 1'b0;
                end else begin
                    n_stage = STG_COARSE; n_start = i_word.now_ms; n_active = 4'hF;
                    n_elapsed = '0; n_fault = FLT_NONE; n_pct = '0;
                    for (int k = 0; k < 4; k++) n_peak[k] = '0;
                    n_done = '0; n_run = 1'b1;
                end
            end
            CMD_STOP: begin
                n_run = 1'b0; n_stage = STG_IDLE; n_active = '0; n_fault = FLT_NONE;
            end
            CMD_UPDATE: begin
                if (r_run) begin
                    n_elapsed = i_word.now_ms - r_start;
                    if (n_elapsed > RUN_LIMIT_MS) begin
                        n_stage = STG_ERROR; n_fault = FLT_TIMEOUT; n_run = 1'b0;
                    end else if (r_stage == STG_COARSE) begin
                        if ((i_word.now_ms - r_last[0]) >= STEP_GAP_MS) begin
                            n_last[0] = i_word.now_ms;
                            for (int k = 0; k < 4; k++) begin
                                if (3'(k) < nl) begin
                                    if (i_lane[k].coarse_done) begin
                                        n_done[k] = 1'b1; n_active[k] = 1'b0;
                                    end else begin
                                        all_d = 1'b0; mv[k] = 1'b1;
                                        g[k] = i_lane[k].coarse_goal;
                                    end
                                end
                            end
                            for (int k = 0; k < 4; k++)
                                if (3'(k) < nl && n_done[k]) cnt = cnt + 3'd1;
                            if (all_d) begin
                                n_stage = STG_FINE; n_pct = 7'd30;
                            end else if (nl != 3'd0) begin
                                n_pct = prog(7'd10, 7'd20, cnt, nl);
                            end
                        end
                    end else if (r_stage == STG_FINE) begin
                        if ((i_word.now_ms - r_last[1]) >= STEP_GAP_MS) begin
                            n_last[1] = i_word.now_ms;
                            for (int k = 0; k < 4; k++) begin
                                if (3'(k) < nl) begin
                                    if (r_done[k]) begin
                                        cnt = cnt + 3'd1;
                                    end else begin
                                        if (k < MOTORS && frc[k] > r_peak[k])
                                            n_peak[k] = frc[k];
                                        if (i_lane[k].fine_done) begin
                                            n_done[k] = 1'b1; n_active[k] = 1'b0;
                                            cnt = cnt + 3'd1;
                                        end else begin
                                            mv[k] = 1'b1; g[k] = i_lane[k].fine_goal;
                                            all_d = 1'b0;
                                        end
                                    end
                                end
                            end
                            if (all_d) begin
                                n_stage = STG_HOLD; n_pct = 7'd80;
                            end else if (nl != 3'd0) begin
                                n_pct = prog(7'd30, 7'd50, cnt, nl);
                            end
                        end
                    end else if (r_stage == STG_HOLD) begin
                        if ((i_word.now_ms - r_last[2]) >= STEP_GAP_MS) begin
                            n_last[2] = i_word.now_ms;
                            for (int k = 0; k < 4; k++) begin
                                if (3'(k) < nl) begin
                                    if (i_lane[k].hold_in) begin
                                        cnt = cnt + 3'd1;
                                    end else begin
                                        all_d = 1'b0;
                                        if (i_lane[k].hold_low) begin
                                            mv[k] = 1'b1; g[k] = i_lane[k].hold_goal;
                                        end
                                    end
                                end
                            end
                            if (all_d) begin
                                n_stage = STG_COMPLETE; n_pct = 7'd100;
                            end else if (nl != 3'd0) begin
                                n_pct = prog(7'd80, 7'd20, cnt, nl);
                            end
                        end
                    end else if (r_stage == STG_COMPLETE || r_stage == STG_ERROR) begin
                        n_run = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; r_stage <= STG_IDLE; r_start <= '0; r_elapsed <= '0;
            r_active <= '0; r_done <= '0; r_pct <= '0; r_fault <= FLT_NONE;
            for (int k = 0; k < 3; k++) r_last[k] <= '0;
            for (int k = 0; k < 4; k++) r_peak[k] <= '0;
        end else if (i_go) begin
            r_run <= n_run; r_stage <= n_stage; r_start <= n_start;
            r_elapsed <= n_elapsed; r_active <= n_active; r_done <= n_done;
            r_pct <= n_pct; r_fault <= n_fault; r_last <= n_last; r_peak <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            o_word.busy_res <= n_run;
            o_word.stage <= n_stage;
            o_word.percent <= n_pct;
            o_word.fault <= n_fault;
            o_word.elapsed <= n_elapsed;
            o_word.move_mask <= mv;
            o_word.goal_a <= g[0];
            o_word.goal_b <= g[1];
            o_word.goal_c <= g[2];
            o_word.goal_d <= g[3];
            o_word.active_bits <= n_active;
        end
    end
endmodule

### rtl/force_calibration_sequencer_top.sv
// Force calibration sequencer for up to four motors.
// Input channel: i_in_valid/o_in_ready carry one command word (update, start or
// stop) with the time, the motor positions and the measured forces.
// Output channel: o_out_valid/i_out_ready carry one result word per command.
// Configuration channel: i_cfg_valid/o_cfg_ready with a register index and data;
// always ready; the user must write it only while idle, the block does not check.
// A word is registered on acceptance; in the next cycle the four lanes evaluate it
// and the merge stage updates the sequencer state and fills the output register,
// so the result is valid once loaded there. One command is in flight at a time;
// the next one is taken in the cycle after its result is accepted.
// Synchronous active-low reset returns to idle and loads the register defaults;
// the output register is not reset. When the receiver stalls, the result holds and
// no new command is accepted.
module force_calibration_sequencer_top #(
    parameter int unsigned MOTORS = fcs_pkg::MOTORS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fcs_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fcs_pkg::t_out_word o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    import fcs_pkg::*;

    t_seq r_seq, n_seq;
    t_in_word r_word;
    logic signed [19:0] r_target;
    logic [15:0] r_rate, r_band;
    logic signed [23:0] r_goal [4];
    logic [2:0] r_count;
    logic [9:0] r_step;
    t_lane_res lane_res [4];
    logic signed [19:0] pos [4];
    logic signed [23:0] frc [4];
    logic go;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready = (r_seq == SEQ_IDLE);
    assign o_out_valid = (r_seq == SEQ_OUT);
    assign go = (r_seq == SEQ_EVAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 20'sd50000; r_rate <= 16'd3330; r_count <= 3'd4;
            r_band <= 16'd10;
            for (int k = 0; k < 4; k++) r_goal[k] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TARGET: r_target <= i_cfg_data[19:0];
                REG_RATE:   r_rate <= i_cfg_data[15:0];
                REG_GOAL_A: r_goal[0] <= i_cfg_data;
                REG_GOAL_B: r_goal[1] <= i_cfg_data;
                REG_GOAL_C: r_goal[2] <= i_cfg_data;
                REG_GOAL_D: r_goal[3] <= i_cfg_data;
                REG_COUNT:  r_count <= i_cfg_data[2:0];
                REG_BAND:   r_band <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Rate divided by 120 through a reciprocal multiply, exact for 16 bits.
    always_ff @(posedge i_clk) begin
        r_step <= 10'((33'(r_rate) * 33'd69906) >> 23);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SEQ_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SEQ_IDLE: if (i_in_valid) n_seq = SEQ_EVAL;
            SEQ_EVAL: n_seq = SEQ_OUT;
            SEQ_OUT:  if (i_out_ready) n_seq = SEQ_IDLE;
            default:  n_seq = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_word <= i_in_data;
        end
    end

    always_comb begin
        pos[0] = r_word.pos_a; pos[1] = r_word.pos_b;
        pos[2] = r_word.pos_c; pos[3] = r_word.pos_d;
        frc[0] = r_word.force_a; frc[1] = r_word.force_b;
        frc[2] = r_word.force_c; frc[3] = r_word.force_d;
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        fcs_lane u_lane (
            .i_pos(pos[k]), .i_frc(frc[k]), .i_goal(r_goal[k]), .i_target(r_target),
            .i_band(r_band), .i_step(r_step), .o_res(lane_res[k])
        );
    end

    fcs_ctrl #(.MOTORS(MOTORS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_word(r_word),
        .i_lane(lane_res), .i_count(r_count), .o_word(o_out_data)
    );
endmodule

### rtl/fcs_checker.sv
module fcs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input fcs_pkg::t_out_word o_out_data
);
    import fcs_pkg::*;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input taken while result pending");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 o_out_valid) else $error("result late");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_data)) else $error("result changed");
    a_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.percent <= 7'd100)) else $error("percent range");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.busy_res) |->
        (o_out_data.stage != STG_IDLE && o_out_data.fault == FLT_NONE))
        else $error("busy state");
endmodule

bind force_calibration_sequencer_top fcs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
);
